// File: rtl/core/profile_sweep_vertex_generator_defines.svh
// Assertion macros; they assume clk and rst in the enclosing module.
`ifndef PROFILE_SWEEP_VERTEX_GENERATOR_DEFINES_SVH
`define PROFILE_SWEEP_VERTEX_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define PSVG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("psvg assertion failed");
`define PSVG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("psvg assertion failed");
`else
`define PSVG_ASSERT_NOW(label, ante, cons)
`define PSVG_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/core/psvg_pkg.sv
package psvg_pkg;

  localparam int COORD_W   = 32;
  localparam int STEP_W    = 13;
  localparam int MAX_STEPS = 4096;
  localparam int TRIG_BITS = 16;
  localparam int NUM_W     = 45;
  localparam int PROD_W    = 46;
  localparam int XY_W      = 20;
  localparam int MUL_W     = COORD_W + XY_W;
  localparam int SUM_W     = MUL_W + 1;
  localparam int EXT_W     = 47;

  localparam logic signed [XY_W-1:0] CORDIC_K = XY_W'(39797);

  localparam logic [1:0] CFG_SWEEP_MODE     = 2'd0;
  localparam logic [1:0] CFG_STEP_COUNT     = 2'd1;
  localparam logic [1:0] CFG_EXTRUDE_LENGTH = 2'd2;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef enum logic [1:0] {
    MODE_REV_X,
    MODE_REV_Y,
    MODE_EXTRUDE,
    MODE_PASS
  } sweep_mode_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic [STEP_W-1:0]         section_index;
  } point_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic signed [COORD_W-1:0] vertex_z;
    logic                      status;
  } vertex_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic                      bad;
    logic                      neg;
  } meta_t;

  typedef struct packed {
    meta_t             meta;
    logic [NUM_W-1:0]  quo;
  } side_t;

  // atan(2^-i) as a fraction of a turn, 2^32 per turn
  function automatic logic signed [31:0] atan_turn(input int i);
    logic signed [31:0] v;
    case (i)
      0:  v = 32'sd536870912;
      1:  v = 32'sd316933406;
      2:  v = 32'sd167458907;
      3:  v = 32'sd85004756;
      4:  v = 32'sd42667331;
      5:  v = 32'sd21354465;
      6:  v = 32'sd10680862;
      7:  v = 32'sd5340245;
      8:  v = 32'sd2670163;
      9:  v = 32'sd1335087;
      10: v = 32'sd667544;
      11: v = 32'sd333772;
      12: v = 32'sd166886;
      13: v = 32'sd83443;
      14: v = 32'sd41722;
      15: v = 32'sd20861;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] smax;
    logic signed [SUM_W-1:0] smin;
    logic signed [COORD_W-1:0] r;
    smax = SUM_W'(64'sd2147483647);
    smin = ~smax;
    if (v > smax) begin
      r = smax[COORD_W-1:0];
    end else if (v < smin) begin
      r = smin[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/core/psvg_divider.sv
module psvg_divider
  import psvg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic [STEP_W-1:0]  steps,
  input  logic               in_valid,
  input  logic [NUM_W-1:0]   in_num,
  input  meta_t              in_meta,
  output logic               out_valid,
  output logic [NUM_W-1:0]   out_quo,
  output meta_t              out_meta
);

  localparam int STAGES = NUM_W;

  logic              vld      [STAGES];
  logic [STEP_W-1:0] rem      [STAGES];
  logic [NUM_W-1:0]  num      [STAGES];
  logic [NUM_W-1:0]  quo      [STAGES];
  meta_t             meta     [STAGES];

  logic              src_vld  [STAGES];
  logic [STEP_W-1:0] src_rem  [STAGES];
  logic [NUM_W-1:0]  src_num  [STAGES];
  logic [NUM_W-1:0]  src_quo  [STAGES];
  meta_t             src_meta [STAGES];
  logic [STEP_W:0]   trial    [STAGES];
  logic [STEP_W-1:0] rem_next [STAGES];
  logic              qbit     [STAGES];

  // restoring division, one quotient bit per stage
  always_comb begin
    src_vld[0]  = in_valid;
    src_rem[0]  = '0;
    src_num[0]  = in_num;
    src_quo[0]  = '0;
    src_meta[0] = in_meta;
    for (int k = 1; k < STAGES; k++) begin
      src_vld[k]  = vld[k-1];
      src_rem[k]  = rem[k-1];
      src_num[k]  = num[k-1];
      src_quo[k]  = quo[k-1];
      src_meta[k] = meta[k-1];
    end
    for (int k = 0; k < STAGES; k++) begin
      trial[k] = {src_rem[k], src_num[k][NUM_W-1]};
      if (trial[k] >= {1'b0, steps}) begin
        rem_next[k] = STEP_W'(trial[k] - {1'b0, steps});
        qbit[k]     = 1'b1;
      end else begin
        rem_next[k] = trial[k][STEP_W-1:0];
        qbit[k]     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < STAGES; k++) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (advance) begin
        vld[k] <= src_vld[k];
      end
      if (advance) begin
        rem[k]  <= rem_next[k];
        num[k]  <= {src_num[k][NUM_W-2:0], 1'b0};
        quo[k]  <= {src_quo[k][NUM_W-2:0], qbit[k]};
        meta[k] <= src_meta[k];
      end
    end
  end

  assign out_valid = vld[STAGES-1];
  assign out_quo   = quo[STAGES-1];
  assign out_meta  = meta[STAGES-1];

endmodule

// File: rtl/core/psvg_cordic.sv
module psvg_cordic
  import psvg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  logic                   in_valid,
  input  logic [31:0]            in_phase,
  input  side_t                  in_side,
  output logic                   out_valid,
  output logic signed [XY_W-1:0] out_cos,
  output logic signed [XY_W-1:0] out_sin,
  output side_t                  out_side
);

  localparam int STAGES = TRIG_BITS;

  logic                   vld      [STAGES];
  logic signed [XY_W-1:0] x        [STAGES];
  logic signed [XY_W-1:0] y        [STAGES];
  logic signed [31:0]     z        [STAGES];
  logic [1:0]             quad     [STAGES];
  side_t                  side     [STAGES];

  logic                   src_vld  [STAGES];
  logic signed [XY_W-1:0] src_x    [STAGES];
  logic signed [XY_W-1:0] src_y    [STAGES];
  logic signed [31:0]     src_z    [STAGES];
  logic [1:0]             src_quad [STAGES];
  side_t                  src_side [STAGES];
  logic signed [XY_W-1:0] x_next   [STAGES];
  logic signed [XY_W-1:0] y_next   [STAGES];
  logic signed [31:0]     z_next   [STAGES];

  logic signed [XY_W-1:0] xf;
  logic signed [XY_W-1:0] yf;

  always_comb begin
    src_vld[0]  = in_valid;
    src_x[0]    = CORDIC_K;
    src_y[0]    = '0;
    src_z[0]    = {2'b00, in_phase[29:0]};
    src_quad[0] = in_phase[31:30];
    src_side[0] = in_side;
    for (int k = 1; k < STAGES; k++) begin
      src_vld[k]  = vld[k-1];
      src_x[k]    = x[k-1];
      src_y[k]    = y[k-1];
      src_z[k]    = z[k-1];
      src_quad[k] = quad[k-1];
      src_side[k] = side[k-1];
    end
    for (int k = 0; k < STAGES; k++) begin
      if (!src_z[k][31]) begin
        x_next[k] = src_x[k] - (src_y[k] >>> k);
        y_next[k] = src_y[k] + (src_x[k] >>> k);
        z_next[k] = src_z[k] - atan_turn(k);
      end else begin
        x_next[k] = src_x[k] + (src_y[k] >>> k);
        y_next[k] = src_y[k] - (src_x[k] >>> k);
        z_next[k] = src_z[k] + atan_turn(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < STAGES; k++) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (advance) begin
        vld[k] <= src_vld[k];
      end
      if (advance) begin
        x[k]    <= x_next[k];
        y[k]    <= y_next[k];
        z[k]    <= z_next[k];
        quad[k] <= src_quad[k];
        side[k] <= src_side[k];
      end
    end
  end

  // quadrant fold
  assign xf = x[STAGES-1];
  assign yf = y[STAGES-1];

  always_comb begin
    case (quad[STAGES-1])
      2'd0: begin
        out_cos = xf;
        out_sin = yf;
      end
      2'd1: begin
        out_cos = -yf;
        out_sin = xf;
      end
      2'd2: begin
        out_cos = -xf;
        out_sin = -yf;
      end
      default: begin
        out_cos = yf;
        out_sin = -xf;
      end
    endcase
  end

  assign out_valid = vld[STAGES-1];
  assign out_side  = side[STAGES-1];

endmodule

// File: rtl/core/psvg_combine.sv
module psvg_combine
  import psvg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  sweep_mode_t            mode,
  input  logic                   in_valid,
  input  logic signed [XY_W-1:0] in_cos,
  input  logic signed [XY_W-1:0] in_sin,
  input  side_t                  in_side,
  output logic                   out_valid,
  output vertex_item_t           out_item
);

  logic                     a_vld;
  logic signed [MUL_W-1:0]  p_uc;
  logic signed [MUL_W-1:0]  p_ws;
  logic signed [MUL_W-1:0]  p_us;
  logic signed [MUL_W-1:0]  p_wc;
  logic signed [EXT_W-1:0]  ext_sum;
  meta_t                    a_meta;

  logic signed [COORD_W-1:0] u;
  logic signed [COORD_W-1:0] w;
  logic signed [EXT_W-1:0]   off;
  logic signed [EXT_W-1:0]   ext_next;

  logic signed [SUM_W-1:0]   sum_u;
  logic signed [SUM_W-1:0]   sum_w;
  logic signed [COORD_W-1:0] r_u;
  logic signed [COORD_W-1:0] r_w;
  logic signed [COORD_W-1:0] r_ext;
  vertex_item_t              item_next;

  // rotate the pair (u, w) by the section angle
  assign u = (mode == MODE_REV_X) ? in_side.meta.point_y : in_side.meta.point_z;
  assign w = (mode == MODE_REV_X) ? in_side.meta.point_z : in_side.meta.point_x;

  assign off      = $signed({2'b00, in_side.quo});
  assign ext_next = EXT_W'(in_side.meta.point_z) + (in_side.meta.neg ? -off : off);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (advance) begin
      a_vld <= in_valid;
    end
    if (advance) begin
      p_uc    <= MUL_W'(u) * MUL_W'(in_cos);
      p_ws    <= MUL_W'(w) * MUL_W'(in_sin);
      p_us    <= MUL_W'(u) * MUL_W'(in_sin);
      p_wc    <= MUL_W'(w) * MUL_W'(in_cos);
      ext_sum <= ext_next;
      a_meta  <= in_side.meta;
    end
  end

  assign sum_u = SUM_W'(p_uc) - SUM_W'(p_ws) + SUM_W'(64'sd1 <<< (TRIG_BITS - 1));
  assign sum_w = SUM_W'(p_us) + SUM_W'(p_wc) + SUM_W'(64'sd1 <<< (TRIG_BITS - 1));
  assign r_u   = sat32(sum_u >>> TRIG_BITS);
  assign r_w   = sat32(sum_w >>> TRIG_BITS);
  assign r_ext = sat32(SUM_W'(ext_sum));

  always_comb begin
    item_next.vertex_x = a_meta.point_x;
    item_next.vertex_y = a_meta.point_y;
    item_next.vertex_z = a_meta.point_z;
    item_next.status   = STATUS_OK;
    case (mode)
      MODE_REV_X: begin
        item_next.vertex_y = r_u;
        item_next.vertex_z = r_w;
      end
      MODE_REV_Y: begin
        item_next.vertex_x = r_w;
        item_next.vertex_z = r_u;
      end
      MODE_EXTRUDE: begin
        item_next.vertex_z = r_ext;
      end
      default: begin
      end
    endcase
    if (a_meta.bad) begin
      item_next.vertex_x = '0;
      item_next.vertex_y = '0;
      item_next.vertex_z = '0;
      item_next.status   = STATUS_RANGE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= a_vld;
    end
    if (advance) begin
      out_item <= item_next;
    end
  end

endmodule

// File: rtl/core/profile_sweep_vertex_generator.sv
// channel   dir  handshake                  payload
// point     in   point_valid / point_stall  point (point_item_t)
// vertex    out  vertex_valid / vertex_stall vertex (vertex_item_t)
// cfg       in   cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One item per cycle while the output is not stalled; the pipeline holds input and
// numerator stages, a 45-stage restoring divider (one quotient bit each), 16 CORDIC
// stages, and multiply and round/saturate stages. A stalled output freezes the whole
// pipeline, so point_stall follows vertex_valid && vertex_stall. Synchronous reset clears
// valid bits and loads mode 1, 16 steps, extrude length 1.0.
`include "profile_sweep_vertex_generator_defines.svh"

module profile_sweep_vertex_generator
  import psvg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               point_valid,
  output logic               point_stall,
  input  point_item_t        point,
  output logic               vertex_valid,
  input  logic               vertex_stall,
  output vertex_item_t       vertex,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  sweep_mode_t              sweep_mode;
  logic [STEP_W-1:0]        step_count;
  logic signed [COORD_W-1:0] extrude_length;

  logic                     advance;
  logic [STEP_W-1:0]        steps;
  logic [STEP_W-1:0]        last;

  logic                     s0_vld;
  point_item_t              s0_point;
  logic signed [PROD_W-1:0] s0_prod;
  logic                     s0_bad;

  logic                     s1_vld;
  logic [NUM_W-1:0]         s1_num;
  meta_t                    s1_meta;

  logic [PROD_W-1:0]        mag;
  logic [NUM_W-1:0]         num_next;
  meta_t                    meta_next;

  logic                     div_vld;
  logic [NUM_W-1:0]         div_quo;
  meta_t                    div_meta;
  side_t                    div_side;

  logic                     cor_vld;
  logic signed [XY_W-1:0]   cor_cos;
  logic signed [XY_W-1:0]   cor_sin;
  side_t                    cor_side;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_mode     <= MODE_REV_Y;
      step_count     <= STEP_W'(16);
      extrude_length <= 32'sd65536;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SWEEP_MODE:     sweep_mode     <= sweep_mode_t'(cfg_data[1:0]);
        CFG_STEP_COUNT:     step_count     <= cfg_data[STEP_W-1:0];
        CFG_EXTRUDE_LENGTH: extrude_length <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign advance     = !vertex_valid || !vertex_stall;
  assign point_stall = !advance;

  always_comb begin
    if (step_count == '0) begin
      steps = STEP_W'(1);
    end else if (step_count > STEP_W'(MAX_STEPS)) begin
      steps = STEP_W'(MAX_STEPS);
    end else begin
      steps = step_count;
    end
    last = (sweep_mode == MODE_REV_X) ? steps - STEP_W'(1) : steps;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
      s1_vld <= 1'b0;
    end else if (advance) begin
      s0_vld <= point_valid;
      s1_vld <= s0_vld;
    end
    if (advance) begin
      s0_point <= point;
      s0_prod  <= PROD_W'(extrude_length) *
                  PROD_W'($signed({1'b0, point.section_index}));
      s0_bad   <= point.section_index > last;
      s1_num   <= num_next;
      s1_meta  <= meta_next;
    end
  end

  // numerator: section turn fraction or rounded extrude magnitude
  assign mag = s0_prod[PROD_W-1] ? PROD_W'(-s0_prod) : PROD_W'(s0_prod);

  always_comb begin
    if (sweep_mode == MODE_REV_X || sweep_mode == MODE_REV_Y) begin
      num_next = {s0_point.section_index, 32'd0};
    end else begin
      num_next = NUM_W'(mag) + NUM_W'(steps >> 1);
    end
    meta_next.point_x = s0_point.point_x;
    meta_next.point_y = s0_point.point_y;
    meta_next.point_z = s0_point.point_z;
    meta_next.bad     = s0_bad;
    meta_next.neg     = s0_prod[PROD_W-1];
  end

  psvg_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .steps    (steps),
    .in_valid (s1_vld),
    .in_num   (s1_num),
    .in_meta  (s1_meta),
    .out_valid(div_vld),
    .out_quo  (div_quo),
    .out_meta (div_meta)
  );

  assign div_side.meta = div_meta;
  assign div_side.quo  = div_quo;

  psvg_cordic u_cordic (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_valid (div_vld),
    .in_phase (div_quo[31:0]),
    .in_side  (div_side),
    .out_valid(cor_vld),
    .out_cos  (cor_cos),
    .out_sin  (cor_sin),
    .out_side (cor_side)
  );

  psvg_combine u_combine (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .mode     (sweep_mode),
    .in_valid (cor_vld),
    .in_cos   (cor_cos),
    .in_sin   (cor_sin),
    .in_side  (cor_side),
    .out_valid(vertex_valid),
    .out_item (vertex)
  );

  `PSVG_ASSERT_NOW(a_range_zero, vertex_valid && vertex.status == STATUS_RANGE, vertex.vertex_x == '0 && vertex.vertex_y == '0 && vertex.vertex_z == '0)
  `PSVG_ASSERT_NOW(a_stall_cause, point_stall, vertex_valid && vertex_stall)
  `PSVG_ASSERT_NEXT(a_mode_write, cfg_valid && cfg_ready && cfg_index == CFG_SWEEP_MODE, sweep_mode == $past(cfg_data[1:0]))

endmodule
